[src/khsip_pkg.sv]
// Shared types and constants for the keyed HalfSipHash-2-4 core.
`default_nettype none

package khsip_pkg;

    // Configuration register indexes
    localparam logic CFG_IDX_KEY  = 1'b0;
    localparam logic CFG_IDX_WIDE = 1'b1;

    // Input stream payload width: data_word (32) + byte_count (3), padded to bytes
    localparam int unsigned S_TDATA_W = 40;

    // Finalisation rounds and their counter
    localparam int unsigned D_ROUNDS = 4;
    localparam int unsigned RCNT_W   = 2;

    // Datapath operations issued by the controller
    typedef enum logic [2:0] {
        OP_HOLD       = 3'd0,  // keep state
        OP_START      = 3'd1,  // take request: (re)load, v3 ^= m, first round
        OP_ABSORB_IN  = 3'd2,  // v3 ^= m, round
        OP_ABSORB_OUT = 3'd3,  // round, v0 ^= m
        OP_FIN_XOR    = 3'd4,  // v2 ^= finalisation constant, round
        OP_OUT_XOR    = 3'd5,  // v1 ^= second-word constant, round
        OP_ROUND      = 3'd6   // plain round
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   cap_lo;  // capture first tag word from round output
        logic   cap_hi;  // capture second tag word from round output
        logic   emit;    // load the output tag register
    } dp_cmd_t;

    typedef struct packed {
        logic last;        // current request closes the message
        logic pend_final;  // a length-only final block is still to absorb
    } dp_stat_t;

endpackage : khsip_pkg

`default_nettype wire

[src/khsip_dp.sv]
// Datapath: SipHash state, shared round unit, length and block formation, tag register.
`default_nettype none

module khsip_dp (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire khsip_pkg::dp_cmd_t cmd,
    output khsip_pkg::dp_stat_t    stat,
    input  wire logic [31:0]       data_word,
    input  wire logic [2:0]        byte_count,
    input  wire logic              last,
    input  wire logic [63:0]       hash_key,
    input  wire logic              wide_output,
    output logic [63:0]            hash_tag
);
    import khsip_pkg::*;

    localparam logic [31:0] IV_V2      = 32'h6c796765;
    localparam logic [31:0] IV_V3      = 32'h74656462;
    localparam logic [31:0] WIDE_MARK  = 32'h000000ee;
    localparam logic [31:0] FIN_NARROW = 32'h000000ff;
    localparam logic [31:0] FIN_SECOND = 32'h000000dd;

    typedef struct packed {
        logic [31:0] v3;
        logic [31:0] v2;
        logic [31:0] v1;
        logic [31:0] v0;
    } sip_state_t;

    function automatic sip_state_t sip_round(input sip_state_t s);
        logic [31:0] a0;
        logic [31:0] a1;
        logic [31:0] a2;
        logic [31:0] a3;
        sip_state_t  r;
        a0 = s.v0 + s.v1;
        a1 = {s.v1[26:0], s.v1[31:27]} ^ a0;
        a0 = {a0[15:0], a0[31:16]};
        a2 = s.v2 + s.v3;
        a3 = {s.v3[23:0], s.v3[31:24]} ^ a2;
        a0 = a0 + a3;
        a3 = {a3[24:0], a3[31:25]} ^ a0;
        a2 = a2 + a1;
        a1 = {a1[18:0], a1[31:19]} ^ a2;
        a2 = {a2[15:0], a2[31:16]};
        r.v0 = a0;
        r.v1 = a1;
        r.v2 = a2;
        r.v3 = a3;
        return r;
    endfunction

    sip_state_t  v_reg, v_next;
    sip_state_t  key_state, base_state, r_in, r_out;
    logic [31:0] m_reg, m_next;
    logic [7:0]  len_reg, len_next;
    logic        in_msg_reg, in_msg_next;
    logic        last_reg, last_next;
    logic        pend_reg, pend_next;
    logic [31:0] lo_reg, lo_next;
    logic [31:0] hi_reg, hi_next;
    logic [63:0] tag_reg, tag_next;

    logic        full_word;
    logic [7:0]  len_base, len_add, len_new;
    logic [23:0] tail;
    logic [31:0] blk_in;

    // Initial state from the key
    always_comb begin
        key_state.v0 = hash_key[31:0];
        key_state.v1 = hash_key[63:32] ^ (wide_output ? WIDE_MARK : 32'h0);
        key_state.v2 = hash_key[31:0] ^ IV_V2;
        key_state.v3 = hash_key[63:32] ^ IV_V3;
        base_state   = in_msg_reg ? v_reg : key_state;
    end

    // Length and block formation for the incoming request
    always_comb begin
        full_word = byte_count[2];
        len_base  = in_msg_reg ? len_reg : 8'd0;
        len_add   = (full_word || !last) ? 8'd4 : {6'd0, byte_count[1:0]};
        len_new   = len_base + len_add;
        unique case (byte_count[1:0])
            2'd0: tail = 24'h000000;
            2'd1: tail = {16'h0000, data_word[7:0]};
            2'd2: tail = {8'h00, data_word[15:0]};
            2'd3: tail = data_word[23:0];
            default: tail = 24'h000000;
        endcase
        blk_in = (last && !full_word) ? {len_new, tail} : data_word;
    end

    // Select round input per operation
    always_comb begin
        r_in = v_reg;
        unique case (cmd.op)
            OP_START:     begin
                r_in    = base_state;
                r_in.v3 = base_state.v3 ^ blk_in;
            end
            OP_ABSORB_IN: r_in.v3 = v_reg.v3 ^ m_reg;
            OP_FIN_XOR:   r_in.v2 = v_reg.v2 ^ (wide_output ? WIDE_MARK : FIN_NARROW);
            OP_OUT_XOR:   r_in.v1 = v_reg.v1 ^ FIN_SECOND;
            OP_HOLD, OP_ABSORB_OUT, OP_ROUND: r_in = v_reg;
            default:      r_in = v_reg;
        endcase
        r_out = sip_round(r_in);
    end

    // Next-state of the datapath registers
    always_comb begin
        v_next      = v_reg;
        m_next      = m_reg;
        len_next    = len_reg;
        in_msg_next = in_msg_reg;
        last_next   = last_reg;
        pend_next   = pend_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        tag_next    = tag_reg;
        unique case (cmd.op)
            OP_HOLD: v_next = v_reg;
            OP_START: begin
                v_next      = r_out;
                m_next      = blk_in;
                len_next    = len_new;
                in_msg_next = !last;
                last_next   = last;
                pend_next   = last && full_word;
            end
            OP_ABSORB_OUT: begin
                v_next    = r_out;
                v_next.v0 = r_out.v0 ^ m_reg;
                // Queue the length-only final block after a full last word
                if (pend_reg) begin
                    m_next    = {len_reg, 24'h000000};
                    pend_next = 1'b0;
                end
            end
            OP_ABSORB_IN, OP_FIN_XOR, OP_OUT_XOR, OP_ROUND: v_next = r_out;
            default: v_next = v_reg;
        endcase
        if (cmd.cap_lo) begin
            lo_next = r_out.v1 ^ r_out.v3;
            hi_next = 32'h0;
        end
        if (cmd.cap_hi) begin
            hi_next = r_out.v1 ^ r_out.v3;
        end
        if (cmd.emit) begin
            tag_next = {hi_reg, lo_reg};
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg    <= 8'd0;
            in_msg_reg <= 1'b0;
            last_reg   <= 1'b0;
            pend_reg   <= 1'b0;
        end else begin
            len_reg    <= len_next;
            in_msg_reg <= in_msg_next;
            last_reg   <= last_next;
            pend_reg   <= pend_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        v_reg   <= v_next;
        m_reg   <= m_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        tag_reg <= tag_next;
    end

    assign stat.last       = last_reg;
    assign stat.pend_final = pend_reg;
    assign hash_tag        = tag_reg;

endmodule : khsip_dp

`default_nettype wire

[src/khsip_ctrl.sv]
// Controller: sequences absorb and finalisation rounds and owns the output valid flag.
`default_nettype none

module khsip_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    output logic                    m_valid,
    input  wire logic               m_ready,
    input  wire logic               wide_output,
    input  wire khsip_pkg::dp_stat_t stat,
    output khsip_pkg::dp_cmd_t      cmd
);
    import khsip_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_ABS_OUT = 5'b00010,
        ST_ABS_IN  = 5'b00100,
        ST_FIN     = 5'b01000,
        ST_EMIT    = 5'b10000
    } state_t;

    localparam logic [RCNT_W-1:0] ROUND_LAST = RCNT_W'(D_ROUNDS - 1);

    state_t            state_reg, state_next;
    logic [RCNT_W-1:0] cnt_reg, cnt_next;
    logic              phase_reg, phase_next;
    logic              out_valid_reg, out_valid_next;

    // Next-state and command decode
    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg && !m_ready;
        s_ready        = 1'b0;
        cmd            = '{op: OP_HOLD, cap_lo: 1'b0, cap_hi: 1'b0, emit: 1'b0};
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op     = OP_START;
                    state_next = ST_ABS_OUT;
                end
            end
            ST_ABS_OUT: begin
                cmd.op = OP_ABSORB_OUT;
                priority if (!stat.last) begin
                    state_next = ST_IDLE;
                end else if (stat.pend_final) begin
                    state_next = ST_ABS_IN;
                end else begin
                    state_next = ST_FIN;
                    cnt_next   = '0;
                    phase_next = 1'b0;
                end
            end
            ST_ABS_IN: begin
                cmd.op     = OP_ABSORB_IN;
                state_next = ST_ABS_OUT;
            end
            ST_FIN: begin
                if (cnt_reg == '0) begin
                    cmd.op = phase_reg ? OP_OUT_XOR : OP_FIN_XOR;
                end else begin
                    cmd.op = OP_ROUND;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == ROUND_LAST) begin
                    if (!phase_reg) begin
                        cmd.cap_lo = 1'b1;
                        if (wide_output) begin
                            phase_next = 1'b1;
                        end else begin
                            state_next = ST_EMIT;
                        end
                    end else begin
                        cmd.cap_hi = 1'b1;
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                // Wait for the output register to free up
                if (!out_valid_reg || m_ready) begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid = out_valid_reg;

    // A request taken always moves on to the second absorb round
    a_start_to_absorb: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_ABS_OUT))
        else $error("request accepted but absorb did not follow");

    // A new tag only appears from the emit step
    a_valid_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_EMIT))
        else $error("output valid raised outside emit");

    // The queued final block is consumed before its absorb starts
    a_pend_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ABS_IN) |-> !stat.pend_final)
        else $error("final block still pending in absorb");

    // Finalisation always begins at round zero of the first word
    a_fin_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_FIN) && ($past(state_reg) == ST_ABS_OUT))
            |-> ((cnt_reg == '0) && !phase_reg))
        else $error("finalisation entered mid-count");

endmodule : khsip_ctrl

`default_nettype wire

[src/keyed_halfsiphash_core.sv]
// Top level of the keyed HalfSipHash-2-4 core: configuration registers and stream ports.
`default_nettype none

// Keyed HalfSipHash-2-4 over a little-endian byte stream, one 32-bit word per
// request. One SipRound is done per clock in a single shared round unit while a
// request is processed. Each word is absorbed with v3 ^= m, its rounds, v0 ^= m;
// a closing word is followed, if it carries four bytes, by a separate length-only
// final block, and then by the finalisation rounds (again for the second word of
// a 64-bit tag) and the output register load. The tag sits in an output register,
// so the next message can start while the previous tag waits to be taken. The user
// must write key and tag width through the configuration channel only while the
// core is idle; the core does not enforce this. The key is read at message start.
module keyed_halfsiphash_core (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // Input stream
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [khsip_pkg::S_TDATA_W-1:0]  s_tdata,   // data_word[31:0], byte_count[34:32]
    input  wire logic                             s_tlast,   // last
    // Result stream
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [63:0]                           m_tdata,   // hash_tag[63:0]
    // Configuration write channel
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic                             cfg_index,
    input  wire logic [63:0]                      cfg_data
);
    import khsip_pkg::*;

    logic [63:0] key_reg, key_next;
    logic        wide_reg, wide_next;
    dp_cmd_t     cmd;
    dp_stat_t    stat;

    // Register writes
    assign cfg_ready = 1'b1;

    always_comb begin
        key_next  = key_reg;
        wide_next = wide_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_IDX_KEY:  key_next  = cfg_data;
                CFG_IDX_WIDE: wide_next = cfg_data[0];
                default:      key_next  = key_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg  <= 64'd0;
            wide_reg <= 1'b1;
        end else begin
            key_reg  <= key_next;
            wide_reg <= wide_next;
        end
    end

    khsip_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_tvalid),
        .s_ready     (s_tready),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .wide_output (wide_reg),
        .stat        (stat),
        .cmd         (cmd)
    );

    khsip_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .data_word   (s_tdata[31:0]),
        .byte_count  (s_tdata[34:32]),
        .last        (s_tlast),
        .hash_key    (key_reg),
        .wide_output (wide_reg),
        .hash_tag    (m_tdata)
    );

endmodule : keyed_halfsiphash_core

`default_nettype wire

[tb/keyed_halfsiphash_core_tb.sv]
// Self-checking testbench for the keyed HalfSipHash-2-4 core, checked against its own predictor.
`timescale 1ns / 1ps

module keyed_halfsiphash_core_tb;

    import khsip_pkg::*;

    localparam logic [31:0] IV_V2       = 32'h6c79_6765;
    localparam logic [31:0] IV_V3       = 32'h7465_6462;
    localparam logic [7:0]  V1_WIDE_IV  = 8'hee;
    localparam logic [7:0]  FIN_WIDE    = 8'hee;
    localparam logic [7:0]  FIN_NARROW  = 8'hff;
    localparam logic [7:0]  SECOND_XOR  = 8'hdd;
    localparam int          C_ROUNDS    = 2;
    localparam int          SETTLE      = 24;
    localparam int          HOLD_CYCLES = 400;
    localparam int          PHASES      = 8;
    localparam int          PHASE_ITEMS = 180;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  cnt;
        logic        last;
    } word_req_t;

    // Directed requests: tail masking, over-long counts, short body words, multi-word messages
    localparam int DIR_N = 21;
    localparam word_req_t DIRECTED [0:DIR_N-1] = '{
        '{32'hffff_ffff, 3'd0, 1'b1},   // empty message, data ignored
        '{32'hffff_ffff, 3'd1, 1'b1},
        '{32'hffff_ffff, 3'd2, 1'b1},
        '{32'hffff_ffff, 3'd3, 1'b1},
        '{32'hffff_ffff, 3'd4, 1'b1},   // full closing word, length-only block follows
        '{32'h0000_0000, 3'd4, 1'b1},
        '{32'ha5a5_a5a5, 3'd7, 1'b1},   // count above four taken as four
        '{32'h5a5a_5a5a, 3'd5, 1'b1},
        '{32'h0123_4567, 3'd4, 1'b0},
        '{32'h89ab_cdef, 3'd4, 1'b0},
        '{32'hdead_beef, 3'd2, 1'b1},
        '{32'hffff_ffff, 3'd0, 1'b0},   // short body word absorbed whole
        '{32'h0000_0000, 3'd6, 1'b0},
        '{32'h1234_5678, 3'd3, 1'b1},
        '{32'h0000_0000, 3'd4, 1'b0},
        '{32'hffff_ffff, 3'd4, 1'b0},
        '{32'h0000_0000, 3'd0, 1'b1},
        '{32'h0302_0100, 3'd4, 1'b0},
        '{32'h0706_0504, 3'd4, 1'b1},
        '{32'h7654_3210, 3'd1, 1'b0},
        '{32'hfedc_ba98, 3'd1, 1'b1}
    };

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;    // data_word[31:0], byte_count[34:32]
    logic                 s_tlast;    // last
    logic                 m_tvalid;
    logic                 m_tready;
    logic [63:0]          m_tdata;    // hash_tag[63:0]
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic                 cfg_index;
    logic [63:0]          cfg_data;

    // Predictor state
    logic [63:0] key_cfg;
    logic        wide_cfg;
    logic [31:0] v0, v1, v2, v3;
    logic [7:0]  len_low;
    logic        msg_open;
    logic [63:0] tag_fifo [$];

    int fails;
    int phase_items;
    bit calm;
    bit hold_req;

    keyed_halfsiphash_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Generous bound on the whole run
    initial begin
        #5_000_000;
        $display("[keyed_halfsiphash_core] ERROR");
        $finish;
    end

    function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned b);
        return (x << b) | (x >> (32 - b));
    endfunction

    function automatic void sip_round();
        v0 = v0 + v1; v1 = rotl(v1, 5);  v1 = v1 ^ v0; v0 = rotl(v0, 16);
        v2 = v2 + v3; v3 = rotl(v3, 8);  v3 = v3 ^ v2;
        v0 = v0 + v3; v3 = rotl(v3, 7);  v3 = v3 ^ v0;
        v2 = v2 + v1; v1 = rotl(v1, 13); v1 = v1 ^ v2; v2 = rotl(v2, 16);
    endfunction

    function automatic void absorb_block(input logic [31:0] m);
        v3 = v3 ^ m;
        for (int i = 0; i < C_ROUNDS; i++) sip_round();
        v0 = v0 ^ m;
    endfunction

    // Advance the predicted hash state by one accepted request; queue the tag on the last one
    function automatic void hash_take_word(input logic [31:0] word, input logic [2:0] cnt_in,
                                           input logic last);
        logic [2:0]  cnt;
        logic [31:0] blk;
        logic [31:0] lo;
        logic [31:0] hi;
        cnt = (cnt_in > 3'd4) ? 3'd4 : cnt_in;
        if (!msg_open) begin
            v0 = key_cfg[31:0];
            v1 = key_cfg[63:32] ^ (wide_cfg ? {24'd0, V1_WIDE_IV} : 32'd0);
            v2 = key_cfg[31:0] ^ IV_V2;
            v3 = key_cfg[63:32] ^ IV_V3;
            len_low = 8'd0;
            msg_open = 1'b1;
        end
        if (!last) begin
            absorb_block(word);
            len_low = len_low + 8'd4;
            return;
        end
        // a full closing word is absorbed first, then a length-only block
        if (cnt == 3'd4) begin
            absorb_block(word);
            word = 32'd0;
            cnt = 3'd0;
            len_low = len_low + 8'd4;
        end else begin
            len_low = len_low + {5'd0, cnt};
        end
        blk = {len_low, 24'd0} | (word & ((32'd1 << (8 * cnt)) - 32'd1));
        absorb_block(blk);
        v2 = v2 ^ {24'd0, (wide_cfg ? FIN_WIDE : FIN_NARROW)};
        for (int i = 0; i < D_ROUNDS; i++) sip_round();
        lo = v1 ^ v3;
        hi = 32'd0;
        if (wide_cfg) begin
            v1 = v1 ^ {24'd0, SECOND_XOR};
            for (int i = 0; i < D_ROUNDS; i++) sip_round();
            hi = v1 ^ v3;
        end
        tag_fifo.push_back({hi, lo});
        msg_open = 1'b0;
        len_low = 8'd0;
    endfunction

    // Present one request, with an occasional gap beforehand; valid stays high on return
    task automatic send_word(input logic [31:0] word, input logic [2:0] cnt, input logic last);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - 35){1'b0}}, cnt, word};
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        hash_take_word(word, cnt, last);
        phase_items++;
    endtask

    // Write one register; valid stays high on return
    task automatic write_reg(input logic idx, input logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == CFG_IDX_KEY) key_cfg = value;
        else wide_cfg = value[0];
    endtask

    // Drop the input and let every outstanding tag and in-flight word drain
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (tag_fifo.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 11))
            0:       return 32'd0;
            1:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // One message: mostly short, sometimes long enough to wrap the length byte
    task automatic random_message();
        int sel;
        int body;
        logic [2:0] cnt;
        sel = $urandom_range(0, 99);
        if (sel < 70) body = $urandom_range(0, 3);
        else if (sel < 95) body = $urandom_range(4, 15);
        else body = $urandom_range(40, 80);
        for (int i = 0; i < body; i++) begin
            cnt = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
            send_word(rand_word(), cnt, 1'b0);
        end
        send_word(rand_word(), 3'($urandom_range(0, 7)), 1'b1);
    endtask

    // Compare every taken tag with the oldest prediction
    always @(posedge aclk) begin : tag_check
        logic [63:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (tag_fifo.size() == 0) begin
                $error("hash_tag: none expected, actual %h", m_tdata);
                fails++;
            end else begin
                want = tag_fifo.pop_front();
                if (m_tdata !== want) begin
                    $error("hash_tag: expected %h, actual %h", want, m_tdata);
                    fails++;
                end
            end
        end
    end

    // Result side: random stalls, one long hold-off on request
    initial begin
        m_tready <= 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge aclk);
                hold_req = 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(0, 18)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Stimulus
    initial begin
        logic [63:0] key_val;
        logic        wide_val;
        fails       = 0;
        phase_items = 0;
        calm        = 1'b0;
        hold_req    = 1'b0;
        key_cfg     = 64'd0;
        wide_cfg    = 1'b1;
        v0 = 32'd0; v1 = 32'd0; v2 = 32'd0; v3 = 32'd0;
        len_low     = 8'd0;
        msg_open    = 1'b0;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_IDX_KEY;
        cfg_data  <= 64'd0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part with the reset settings
        for (int i = 0; i < DIR_N; i++)
            send_word(DIRECTED[i].word, DIRECTED[i].cnt, DIRECTED[i].last);
        wait_drained();

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       begin key_val = '1;    wide_val = 1'b0; end
                1:       begin key_val = 64'd0; wide_val = 1'b1; end
                4:       begin key_val = {$urandom, $urandom}; wide_val = ~wide_cfg; end
                default: begin key_val = {$urandom, $urandom}; wide_val = 1'($urandom_range(0, 1)); end
            endcase
            // upper bits of the mode write are junk on purpose
            write_reg(CFG_IDX_KEY, key_val);
            write_reg(CFG_IDX_WIDE, ({$urandom, $urandom} & ~64'd1) | {63'd0, wide_val});
            cfg_valid <= 1'b0;
            @(posedge aclk);

            if (ph == 5) hold_req = 1'b1;
            if (ph == PHASES - 1) calm = 1'b1;
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) random_message();
            // leave a message open across the next register writes
            if (ph == 3) begin
                send_word($urandom, 3'd4, 1'b0);
                send_word($urandom, 3'd4, 1'b0);
            end
            wait_drained();
        end

        if (fails == 0 && tag_fifo.size() == 0) begin
            $display("[keyed_halfsiphash_core] OK");
        end else begin
            $display("[keyed_halfsiphash_core] ERROR");
        end
        $finish;
    end

endmodule
